// File: rtl/pra_pkg.sv
`timescale 1ns / 1ps
package pra_pkg;
  localparam int unsigned MaxRangesDefault = 64;
  localparam int unsigned PageBytesDefault = 4096;
  localparam int unsigned PagesW = 21;
  localparam int unsigned AddrW = 32;
  localparam logic [PagesW-1:0] PagesMax = {PagesW{1'b1}};

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_NOBASE  = 3'd2,
    ST_NOTUSED = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  // One table entry as stored in the range memory.
  typedef struct packed {
    logic [AddrW-1:0]  base;
    logic [PagesW-1:0] pages;
    logic              used;
  } entry_t;
endpackage

// File: rtl/page_range_allocator.sv
`timescale 1ns / 1ps
// Page range allocator. Each beat on the input stream is one command (add a free
// range, allocate pages first fit, or free a range by base) and produces exactly one
// result beat. The range table lives in a single memory with a registered read. All
// work is done by a sequencer that reads, modifies and writes one entry per step.
// The table holds at most MAX_RANGES ranges. A command is first taken; then each
// scanned entry is read and examined, each entry moved up for an insert or a split
// is read and written, the new entry is placed, and an allocated or freed entry is
// written back. An add or a successful free then runs a coalescing sweep; each
// merge moves the later entries down and restarts at the merged entry. All steps
// share the single memory port, and the result is presented last. One command is
// in work at a time, and a new command is taken only once the previous result beat
// has left. PAGE_BYTES must be a power of two, since page counts and addresses are
// converted by shifts. No clearing pass is needed after reset: only entries below
// the fill count are ever used.
module page_range_allocator #(
  parameter int unsigned MAX_RANGES = pra_pkg::MaxRangesDefault,
  parameter int unsigned PAGE_BYTES = pra_pkg::PageBytesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: range_start[31:0], range_end[63:32], page_count[84:64], zero fill
  input  logic [87:0] in_tdata,
  // in_tuser: operation[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: alloc_address[31:0], freed_pages[52:32], zero fill
  output logic [55:0] out_tdata,
  // out_tuser: status[2:0]
  output logic [2:0]  out_tuser
);
  localparam int unsigned IdxW = $clog2(MAX_RANGES);
  localparam int unsigned CntW = $clog2(MAX_RANGES + 1);
  localparam int unsigned AW = pra_pkg::AddrW;
  localparam int unsigned PW = pra_pkg::PagesW;
  localparam int unsigned PageShift = $clog2(PAGE_BYTES);
  localparam logic [CntW-1:0] CntFull = CntW'(MAX_RANGES);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_PLACE, S_WB,
    S_CO_RD, S_CO_A, S_CO_B, S_CL_RD, S_CL_WR, S_RESULT
  } state_t;

  pra_pkg::entry_t mem [MAX_RANGES];
  pra_pkg::entry_t rd_q;
  logic [IdxW-1:0] rd_addr;
  logic            we;
  logic [IdxW-1:0] wr_addr;
  pra_pkg::entry_t wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  state_t            state_r;
  logic [CntW-1:0]   count_r;
  logic [CntW-1:0]   idx_r;     // scan / shift / coalesce pointer
  logic [CntW-1:0]   pos_r;     // insert or hit position
  pra_pkg::op_t      op_r;
  logic [AW-1:0]     start_r;
  logic [PW-1:0]     span_r;    // add: span; alloc: request
  pra_pkg::entry_t   hold_r;    // hit entry or coalesce left entry
  pra_pkg::entry_t   ins_r;     // entry placed at pos_r after shifting up
  logic              split_r;
  logic [2:0]        status_r;
  logic [AW-1:0]     addr_r;
  logic [PW-1:0]     freed_r;
  logic              ovalid_r;

  // Span of an add: (end - start) / PAGE_BYTES, saturated to the page field.
  logic [AW-1:0] diff;
  logic [AW-1:0] span_full;
  logic [PW-1:0] span_sat;
  logic [PW-1:0] req_in;
  assign diff      = in_tdata[63:32] - in_tdata[31:0];
  assign span_full = diff >> PageShift;
  assign span_sat  = (span_full > AW'(pra_pkg::PagesMax)) ? pra_pkg::PagesMax
                                                          : span_full[PW-1:0];
  assign req_in    = (in_tdata[84:64] == '0) ? PW'(1) : in_tdata[84:64];

  logic [AW-1:0] hold_end;
  logic [PW:0]   pair_sum;
  logic          can_merge;
  assign hold_end  = hold_r.base + (AW'(hold_r.pages) << PageShift);
  assign pair_sum  = {1'b0, hold_r.pages} + {1'b0, rd_q.pages};
  assign can_merge = !hold_r.used && !rd_q.used && (hold_end == rd_q.base) &&
                     !pair_sum[PW];

  logic scan_last;
  logic alloc_fit;
  logic base_match;
  assign scan_last  = (idx_r + 1'b1 == count_r);
  assign alloc_fit  = !rd_q.used && (rd_q.pages >= span_r);
  assign base_match = (rd_q.base == start_r);

  assign in_tready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {3'b000, freed_r, addr_r};
  assign out_tuser  = status_r;

  always_comb begin
    rd_addr = idx_r[IdxW-1:0];
    we      = 1'b0;
    wr_addr = idx_r[IdxW-1:0];
    wr_data = hold_r;
    unique case (state_r)
      S_SHIFT_RD: rd_addr = IdxW'(idx_r - 1'b1);
      S_SHIFT_WR: begin
        we = 1'b1;
        wr_data = rd_q;
      end
      S_PLACE: begin
        we = 1'b1;
        wr_addr = pos_r[IdxW-1:0];
        wr_data = ins_r;
      end
      S_WB: begin
        we = 1'b1;
        wr_addr = pos_r[IdxW-1:0];
      end
      S_CO_A: rd_addr = IdxW'(idx_r + 1'b1);
      S_CO_B: begin
        rd_addr = IdxW'(idx_r + 1'b1);
        we = can_merge;
        wr_addr = IdxW'(idx_r - 1'b1);
        wr_data = '{base: hold_r.base, pages: pair_sum[PW-1:0], used: 1'b0};
      end
      S_CL_RD: rd_addr = IdxW'(idx_r + 1'b1);
      S_CL_WR: begin
        we = 1'b1;
        wr_data = rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && out_tready) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r     <= pra_pkg::op_t'(in_tuser);
            start_r  <= in_tdata[31:0];
            span_r   <= (in_tuser == pra_pkg::OP_ADD) ? span_sat : req_in;
            idx_r    <= '0;
            pos_r    <= '0;
            split_r  <= 1'b0;
            status_r <= pra_pkg::ST_OK;
            addr_r   <= '0;
            freed_r  <= '0;
            priority if (in_tuser == pra_pkg::OP_NONE) begin
              state_r <= S_RESULT;
            end else if (in_tuser == pra_pkg::OP_ADD && count_r >= CntFull) begin
              status_r <= pra_pkg::ST_FULL;
              state_r  <= S_RESULT;
            end else if (count_r == '0) begin
              priority case (in_tuser)
                pra_pkg::OP_ADD: begin
                  ins_r   <= '{base: in_tdata[31:0], pages: span_sat, used: 1'b0};
                  state_r <= S_PLACE;
                end
                pra_pkg::OP_ALLOC: begin
                  status_r <= pra_pkg::ST_NOFIT;
                  state_r  <= S_RESULT;
                end
                default: begin
                  status_r <= pra_pkg::ST_NOBASE;
                  state_r  <= S_RESULT;
                end
              endcase
            end else begin
              state_r <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: state_r <= S_SCAN;
        S_SCAN: begin
          unique case (op_r)
            pra_pkg::OP_ADD: begin
              // The new entry goes after the last entry with a lower base.
              if (rd_q.base < start_r) pos_r <= idx_r + 1'b1;
              if (scan_last) begin
                ins_r   <= '{base: start_r, pages: span_r, used: 1'b0};
                idx_r   <= count_r;
                state_r <= S_SHIFT_RD;
              end else begin
                idx_r   <= idx_r + 1'b1;
                state_r <= S_SCAN_RD;
              end
            end
            pra_pkg::OP_ALLOC: begin
              priority if (alloc_fit && rd_q.pages == span_r) begin
                // Exact fit: mark the entry used in place.
                addr_r  <= rd_q.base;
                hold_r  <= '{base: rd_q.base, pages: rd_q.pages, used: 1'b1};
                pos_r   <= idx_r;
                state_r <= S_WB;
              end else if (alloc_fit && count_r >= CntFull) begin
                // The remainder would need a slot that is not there.
                status_r <= pra_pkg::ST_FULL;
                state_r  <= S_RESULT;
              end else if (alloc_fit) begin
                addr_r  <= rd_q.base;
                split_r <= 1'b1;
                ins_r   <= '{base: rd_q.base + (AW'(span_r) << PageShift),
                             pages: rd_q.pages - span_r, used: 1'b0};
                pos_r   <= idx_r + 1'b1;
                hold_r  <= '{base: rd_q.base, pages: span_r, used: 1'b1};
                idx_r   <= count_r;
                state_r <= S_SHIFT_RD;
              end else if (scan_last) begin
                status_r <= pra_pkg::ST_NOFIT;
                state_r  <= S_RESULT;
              end else begin
                idx_r   <= idx_r + 1'b1;
                state_r <= S_SCAN_RD;
              end
            end
            default: begin
              priority if (base_match && !rd_q.used) begin
                status_r <= pra_pkg::ST_NOTUSED;
                state_r  <= S_RESULT;
              end else if (base_match) begin
                freed_r <= rd_q.pages;
                hold_r  <= '{base: rd_q.base, pages: rd_q.pages, used: 1'b0};
                pos_r   <= idx_r;
                state_r <= S_WB;
              end else if (scan_last) begin
                status_r <= pra_pkg::ST_NOBASE;
                state_r  <= S_RESULT;
              end else begin
                idx_r   <= idx_r + 1'b1;
                state_r <= S_SCAN_RD;
              end
            end
          endcase
        end
        S_SHIFT_RD: begin
          state_r <= (idx_r == pos_r) ? S_PLACE : S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          idx_r   <= idx_r - 1'b1;
          state_r <= S_SHIFT_RD;
        end
        S_PLACE: begin
          count_r <= count_r + 1'b1;
          if (split_r) begin
            // Write the used head of the split entry next.
            split_r <= 1'b0;
            pos_r   <= pos_r - 1'b1;
            state_r <= S_WB;
          end else begin
            idx_r   <= '0;
            state_r <= S_CO_RD;
          end
        end
        S_WB: begin
          if (op_r == pra_pkg::OP_ALLOC) begin
            state_r <= S_RESULT;
          end else begin
            idx_r   <= '0;
            state_r <= S_CO_RD;
          end
        end
        S_CO_RD: begin
          if (idx_r + 1'b1 >= count_r) begin
            state_r <= S_RESULT;
          end else begin
            state_r <= S_CO_A;
          end
        end
        S_CO_A: begin
          hold_r  <= rd_q;
          idx_r   <= idx_r + 1'b1;
          state_r <= S_CO_B;
        end
        S_CO_B: begin
          if (can_merge) begin
            hold_r <= '{base: hold_r.base, pages: pair_sum[PW-1:0], used: 1'b0};
            if (idx_r + 1'b1 < count_r) begin
              pos_r   <= idx_r;
              state_r <= S_CL_RD;
            end else begin
              // The absorbed entry was the last one, so nothing moves down.
              count_r <= count_r - 1'b1;
              idx_r   <= idx_r - 1'b1;
              state_r <= S_CO_RD;
            end
          end else if (idx_r + 1'b1 >= count_r) begin
            state_r <= S_RESULT;
          end else begin
            hold_r  <= rd_q;
            idx_r   <= idx_r + 1'b1;
            state_r <= S_CO_B;
          end
        end
        S_CL_RD: state_r <= S_CL_WR;
        S_CL_WR: begin
          if (idx_r + 1'b1 >= count_r - 1'b1) begin
            // Removal shift done: drop last entry and resume merging at the left one.
            count_r <= count_r - 1'b1;
            idx_r   <= pos_r - 1'b1;
            state_r <= S_CO_RD;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_CL_RD;
          end
        end
        S_RESULT: begin
          if (!ovalid_r || out_tready) begin
            ovalid_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/pra_checker.sv
`timescale 1ns / 1ps
module pra_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [2:0]  out_tuser
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= pra_pkg::ST_FULL)
    else $error("status out of range");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != pra_pkg::ST_OK |-> out_tdata == '0)
    else $error("failing result carries data");
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken while busy");
endmodule

bind page_range_allocator pra_checker u_pra_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the page range allocator.
//
// Commands go in as beats on the input stream and each one yields exactly one
// result beat. A behavioral copy of the range table runs alongside the block.
// Every accepted command is applied to that copy at once, and the result it
// gives is queued. A checker pops the oldest queued result for each result
// beat and compares status, address and freed page count.
//
// A directed part comes first. It covers the empty table, the unused opcode,
// a zero page request, double frees, equal bases, wrapping spans and the
// coalescing limit. A long stretch of back-pressure on the result side then
// fills the block up. After that comes a large random part built around a
// grid of page-aligned slots, so that adds touch and coalesce, allocations
// split and frees find live bases. Some noise is mixed in.
module tb_top;
  import pra_pkg::*;

  localparam int unsigned NumRanges = 64;
  localparam int unsigned PageSize  = 4096;
  localparam int unsigned MaxCycles = 4000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;

  page_range_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // One predicted result beat.
  typedef struct {
    status_t           status;
    logic [AddrW-1:0]  addr;
    logic [PagesW-1:0] freed;
  } alloc_result_t;

  alloc_result_t pending_results[$];

  // Shadow copy of the range table, kept sorted by base.
  logic [AddrW-1:0]  shadow_base [NumRanges];
  logic [PagesW-1:0] shadow_pages[NumRanges];
  logic              shadow_used [NumRanges];
  int unsigned       shadow_count;

  int unsigned errors;
  int unsigned cycle_count;
  bit          steady_flow;   // No idling on either side while set.
  bit          hold_request;  // Asks the receiver for one long hold-off.

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop, far beyond the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [AddrW-1:0] shadow_end(int unsigned idx);
    return shadow_base[idx] + AddrW'(shadow_pages[idx]) * AddrW'(PageSize);
  endfunction

  function automatic void shadow_open(int unsigned pos);
    for (int unsigned k = shadow_count; k > pos; k--) begin
      shadow_base[k]  = shadow_base[k-1];
      shadow_pages[k] = shadow_pages[k-1];
      shadow_used[k]  = shadow_used[k-1];
    end
    shadow_count++;
  endfunction

  function automatic void shadow_close(int unsigned pos);
    for (int unsigned k = pos; k + 1 < shadow_count; k++) begin
      shadow_base[k]  = shadow_base[k+1];
      shadow_pages[k] = shadow_pages[k+1];
      shadow_used[k]  = shadow_used[k+1];
    end
    shadow_count--;
  endfunction

  // Merge touching free neighbors. A merge is skipped when the page sum
  // would not fit in the page field.
  function automatic void shadow_coalesce();
    int unsigned idx;
    logic [PagesW:0] sum;
    idx = 0;
    while (idx + 1 < shadow_count) begin
      sum = {1'b0, shadow_pages[idx]} + {1'b0, shadow_pages[idx+1]};
      if (!shadow_used[idx] && !shadow_used[idx+1] &&
          shadow_end(idx) == shadow_base[idx+1] && sum <= {1'b0, PagesMax}) begin
        shadow_pages[idx] = sum[PagesW-1:0];
        shadow_close(idx + 1);
      end else begin
        idx++;
      end
    end
  endfunction

  // Apply one command to the shadow table and return the result it yields.
  function automatic alloc_result_t apply_command(op_t op, logic [31:0] start,
                                                  logic [31:0] stop,
                                                  logic [PagesW-1:0] want);
    alloc_result_t r;
    logic [31:0] span;
    int unsigned pos;
    int unsigned hit;
    r.status = ST_OK;
    r.addr   = '0;
    r.freed  = '0;
    case (op)
      OP_ADD: begin
        if (shadow_count >= NumRanges) begin
          r.status = ST_FULL;
        end else begin
          span = (stop - start) / PageSize;
          if (span > 32'(PagesMax)) span = 32'(PagesMax);
          pos = 0;
          for (int unsigned i = 0; i < shadow_count; i++)
            if (shadow_base[i] < start) pos = i + 1;
          shadow_open(pos);
          shadow_base[pos]  = start;
          shadow_pages[pos] = span[PagesW-1:0];
          shadow_used[pos]  = 1'b0;
          shadow_coalesce();
        end
      end
      OP_ALLOC: begin
        if (want == '0) want = 1;
        hit = shadow_count;
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (!shadow_used[i] && shadow_pages[i] >= want) begin
            hit = i;
            break;
          end
        end
        if (hit == shadow_count) begin
          r.status = ST_NOFIT;
        end else if (shadow_pages[hit] > want && shadow_count >= NumRanges) begin
          r.status = ST_FULL;
        end else begin
          if (shadow_pages[hit] > want) begin
            shadow_open(hit + 1);
            shadow_base[hit+1]  = shadow_base[hit] + AddrW'(want) * AddrW'(PageSize);
            shadow_pages[hit+1] = shadow_pages[hit] - want;
            shadow_used[hit+1]  = 1'b0;
            shadow_pages[hit]   = want;
          end
          shadow_used[hit] = 1'b1;
          r.addr = shadow_base[hit];
        end
      end
      OP_FREE: begin
        hit = shadow_count;
        for (int unsigned i = 0; i < shadow_count; i++) begin
          if (shadow_base[i] == start) begin
            hit = i;
            break;
          end
        end
        if (hit == shadow_count) begin
          r.status = ST_NOBASE;
        end else if (!shadow_used[hit]) begin
          r.status = ST_NOTUSED;
        end else begin
          shadow_used[hit] = 1'b0;
          r.freed = shadow_pages[hit];
          shadow_coalesce();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one command and hold it until the block takes it. The valid stays
  // high across back-to-back beats and is only lowered for a real gap.
  task automatic send_command(op_t op, logic [31:0] start, logic [31:0] stop,
                              logic [PagesW-1:0] want);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {3'b000, want, stop, start};
    in_tuser  = op;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_command(op, start, stop, want));
    @(negedge clk);
  endtask

  // Stop offering and wait until every queued result has come back.
  task automatic wait_all_results();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Result side: a random stall before each beat, or one long hold-off
  // on request.
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_tready = 1'b0;
        repeat (600) @(negedge clk);
        hold_request = 1'b0;
      end
      stall = steady_flow ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d addr=%h freed=%h",
                 $time, out_tuser, out_tdata[31:0], out_tdata[52:32]);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tuser !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, exp_r.status, out_tuser);
          errors++;
        end
        if (out_tdata[31:0] !== exp_r.addr) begin
          $display("%0t: alloc_address expected %h actual %h",
                   $time, exp_r.addr, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[52:32] !== exp_r.freed) begin
          $display("%0t: freed_pages expected %h actual %h",
                   $time, exp_r.freed, out_tdata[52:32]);
          errors++;
        end
      end
    end
  end

  // Hand-picked corner cases. The huge wrapping ranges come last and are then
  // partly allocated.
  task automatic test_corner_cases();
    send_command(OP_FREE, 32'h0000_1000, '0, '0);   // empty table, no base
    send_command(OP_ALLOC, '0, '0, 21'd5);          // empty table, no fit
    send_command(OP_NONE, '1, '1, '1);              // unused opcode
    send_command(OP_ADD, 32'h0000_1000, 32'h0000_9000, '0);
    send_command(OP_ADD, 32'h0000_1000, 32'h0000_1000, '0);  // equal base, no pages
    send_command(OP_ALLOC, '0, '0, '0);             // zero counts as one page
    send_command(OP_ALLOC, '0, '0, 21'd3);
    send_command(OP_ALLOC, '0, '0, 21'd4);          // exact fit, no split
    send_command(OP_ALLOC, '0, '0, 21'd1);
    send_command(OP_FREE, 32'h0000_1000, '0, '0);
    send_command(OP_FREE, 32'h0000_1000, '0, '0);   // double free
    send_command(OP_FREE, 32'h0001_2345, '0, '0);   // base not present
    send_command(OP_ALLOC, '0, '0, PagesMax);       // too large
    send_command(OP_FREE, 32'h0000_2000, '0, '0);
    send_command(OP_FREE, 32'h0000_5000, '0, '0);
    // Two near-maximal spans and a short wrapping one are added. None of them
    // touches its neighbor in base order, so all three stay separate.
    send_command(OP_ADD, 32'h0000_0000, 32'hFFFF_F000, '0);
    send_command(OP_ADD, 32'hFFFF_F000, 32'hFFFF_E000, '0);
    send_command(OP_ADD, 32'hFFFF_E000, 32'h0000_0000, '0);
    send_command(OP_ALLOC, '0, '0, 21'h10_0000);
    send_command(OP_ALLOC, '0, '0, 21'h0F_FFFE);
    send_command(OP_ALLOC, '0, '0, 21'd2);
    send_command(OP_ALLOC, '0, '0, 21'd1);
    wait_all_results();
  endtask

  // The receiver holds off for a long time while commands keep coming, so
  // the block must stall its input.
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    steady_flow  = 1'b1;
    for (int i = 0; i < 8; i++)
      send_command(OP_ADD, 32'h2000_0000 + i * 32'h2000,
                   32'h2000_2000 + i * 32'h2000, '0);
    steady_flow = 1'b0;
    wait_all_results();
  endtask

  // Pick the base of a random entry, preferring one that is in use.
  function automatic logic [31:0] pick_live_base();
    int unsigned live[$];
    for (int unsigned i = 0; i < shadow_count; i++)
      if (shadow_used[i]) live.push_back(i);
    if (live.size() != 0) return shadow_base[live[$urandom_range(0, live.size() - 1)]];
    if (shadow_count != 0) return shadow_base[$urandom_range(0, shadow_count - 1)];
    return $urandom();
  endfunction

  // Mostly well-formed traffic on a grid of 16-page slots, so that ranges
  // touch, split and coalesce. The rest is noise with random fields.
  task automatic test_random_traffic(int unsigned num_cmds);
    int unsigned pick;
    logic [31:0] base;
    for (int unsigned n = 0; n < num_cmds; n++) begin
      if (n % 200 == 100) steady_flow = 1'b1;
      if (n % 200 == 140) steady_flow = 1'b0;
      if (n % 300 == 299) wait_all_results();
      pick = $urandom_range(0, 99);
      base = 32'h4000_0000 + $urandom_range(0, 127) * 32'h1_0000;
      if (pick < 30) begin
        send_command(OP_ADD, base, base + 32'h1_0000, '0);
      end else if (pick < 36) begin
        send_command(OP_ADD, base, base + $urandom_range(0, 40) * PageSize, '0);
      end else if (pick < 66) begin
        send_command(OP_ALLOC, '0, '0, PagesW'($urandom_range(0, 20)));
      end else if (pick < 90) begin
        send_command(OP_FREE, pick_live_base(), '0, '0);
      end else if (pick < 93) begin
        send_command(OP_FREE, $urandom(), $urandom(), PagesW'($urandom()));
      end else if (pick < 95) begin
        send_command(OP_ALLOC, $urandom(), $urandom(), PagesW'($urandom()));
      end else if (pick < 97) begin
        send_command(OP_ADD, $urandom(), $urandom(), PagesW'($urandom()));
      end else begin
        send_command(OP_NONE, $urandom(), $urandom(), PagesW'($urandom()));
      end
    end
    wait_all_results();
  endtask

  initial begin
    errors       = 0;
    cycle_count  = 0;
    shadow_count = 0;
    steady_flow  = 1'b0;
    hold_request = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = OP_ADD;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_corner_cases();
    test_output_backpressure();
    test_random_traffic(1270);

    repeat (600) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
